FILE: sv/dwrs_pkg.sv
// Package for the demand weighted refill scheduler.
// Word types, function and status codes, sequencer states, ALU ops.
// No dependencies.
`default_nettype none

package dwrs_pkg;

    localparam int KEY_W   = 11;
    localparam int SCORE_W = 32;
    localparam int COUNT_W = 8;
    localparam int LIMIT_W = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [APB_AW-3:0] REG_STOCK_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        FN_TAKE    = 2'd0,
        FN_QUERY   = 2'd1,
        FN_PICK    = 2'd2,
        FN_DEPOSIT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_FINISH,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ALU_DEC,
        ALU_ADD_SAT,
        ALU_LT
    } t_alu_op;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   size_key;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic               created;
        t_status            status;
        logic [COUNT_W-1:0] stock_count;
        logic               pick_valid;
        logic [KEY_W-1:0]   pick_size;
    } t_out_word;

    typedef struct packed {
        logic key;
        logic score;
        logic stock;
    } t_tbl_we;

endpackage

`default_nettype wire

FILE: sv/dwrs_alu.sv
// Shared 32-bit arithmetic unit: saturating decrement, saturating add, less-than.
// Depends on dwrs_pkg.
`default_nettype none

module dwrs_alu (
    input  wire dwrs_pkg::t_alu_op           i_op,
    input  wire [dwrs_pkg::SCORE_W-1:0]      i_a,
    input  wire [dwrs_pkg::SCORE_W-1:0]      i_b,
    output logic [dwrs_pkg::SCORE_W-1:0]     o_res,
    output logic                             o_flag
);

    logic [dwrs_pkg::SCORE_W-1:0] w_b_eff;
    logic                         w_cin;
    logic [dwrs_pkg::SCORE_W:0]   w_sum;

    always_comb begin
        case (i_op)
            dwrs_pkg::ALU_DEC: begin
                w_b_eff = (i_a != '0) ? '1 : '0;
                w_cin   = 1'b0;
            end
            dwrs_pkg::ALU_ADD_SAT: begin
                w_b_eff = i_b;
                w_cin   = 1'b0;
            end
            dwrs_pkg::ALU_LT: begin
                w_b_eff = ~i_b;
                w_cin   = 1'b1;
            end
            default: begin
                w_b_eff = i_b;
                w_cin   = 1'b0;
            end
        endcase
    end

    assign w_sum = {1'b0, i_a} + {1'b0, w_b_eff} + {{dwrs_pkg::SCORE_W{1'b0}}, w_cin};

    always_comb begin
        o_res  = w_sum[dwrs_pkg::SCORE_W-1:0];
        o_flag = 1'b0;
        case (i_op)
            dwrs_pkg::ALU_ADD_SAT: begin
                if (w_sum[dwrs_pkg::SCORE_W]) begin
                    o_res = '1;
                end
            end
            dwrs_pkg::ALU_LT: begin
                // no carry out of a - b means a < b
                o_flag = ~w_sum[dwrs_pkg::SCORE_W];
            end
            default: begin
                o_flag = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/dwrs_table.sv
// Pool table memories: key, score and stock, one write and one read port.
// Depends on dwrs_pkg.
`default_nettype none

module dwrs_table #(
    parameter int MAX_POOLS  = 8,
    parameter int STOCK_BITS = 8
) (
    input  wire                                               i_clk,
    input  wire [((MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1)-1:0] i_rd_addr,
    input  wire [((MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1)-1:0] i_wr_addr,
    input  wire dwrs_pkg::t_tbl_we                            i_we,
    input  wire [dwrs_pkg::KEY_W-1:0]                         i_wr_key,
    input  wire [dwrs_pkg::SCORE_W-1:0]                       i_wr_score,
    input  wire [STOCK_BITS-1:0]                              i_wr_stock,
    output logic [dwrs_pkg::KEY_W-1:0]                        o_rd_key,
    output logic [dwrs_pkg::SCORE_W-1:0]                      o_rd_score,
    output logic [STOCK_BITS-1:0]                             o_rd_stock
);

    logic [dwrs_pkg::KEY_W-1:0]   mem_key   [MAX_POOLS];
    logic [dwrs_pkg::SCORE_W-1:0] mem_score [MAX_POOLS];
    logic [STOCK_BITS-1:0]        mem_stock [MAX_POOLS];

    always_ff @(posedge i_clk) begin
        if (i_we.key) begin
            mem_key[i_wr_addr] <= i_wr_key;
        end
        if (i_we.score) begin
            mem_score[i_wr_addr] <= i_wr_score;
        end
        if (i_we.stock) begin
            mem_stock[i_wr_addr] <= i_wr_stock;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_key   <= mem_key[i_rd_addr];
        o_rd_score <= mem_score[i_rd_addr];
        o_rd_stock <= mem_stock[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/dwrs_seq.sv
// Sequencer: walks the valid table entries one per read/exec pair, drives the
// shared ALU and table writes, and collects the result word. Depends on dwrs_pkg.
`default_nettype none

module dwrs_seq #(
    parameter int MAX_POOLS  = 8,
    parameter int STOCK_BITS = 8
) (
    input  wire                                               i_clk,
    input  wire                                               i_rst_n,
    input  wire                                               i_start,
    input  wire dwrs_pkg::t_in_word                           i_in_word,
    input  wire [dwrs_pkg::LIMIT_W-1:0]                       i_stock_limit,
    input  wire                                               i_out_free,
    output logic                                              o_busy,
    output logic                                              o_done,
    output dwrs_pkg::t_out_word                               o_result,
    output logic [((MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1)-1:0] o_rd_addr,
    output logic [((MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1)-1:0] o_wr_addr,
    output dwrs_pkg::t_tbl_we                                 o_we,
    output logic [dwrs_pkg::KEY_W-1:0]                        o_wr_key,
    output logic [dwrs_pkg::SCORE_W-1:0]                      o_wr_score,
    output logic [STOCK_BITS-1:0]                             o_wr_stock,
    input  wire [dwrs_pkg::KEY_W-1:0]                         i_rd_key,
    input  wire [dwrs_pkg::SCORE_W-1:0]                       i_rd_score,
    input  wire [STOCK_BITS-1:0]                              i_rd_stock,
    output dwrs_pkg::t_alu_op                                 o_alu_op,
    output logic [dwrs_pkg::SCORE_W-1:0]                      o_alu_a,
    output logic [dwrs_pkg::SCORE_W-1:0]                      o_alu_b,
    input  wire [dwrs_pkg::SCORE_W-1:0]                       i_alu_res,
    input  wire                                               i_alu_flag
);

    localparam int IDX_W = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int CNT_W = $clog2(MAX_POOLS + 1);
    localparam int RPT_W = (STOCK_BITS > dwrs_pkg::COUNT_W) ? STOCK_BITS : dwrs_pkg::COUNT_W;

    dwrs_pkg::t_state  r_state, n_state;
    dwrs_pkg::t_func   r_func, n_func;
    dwrs_pkg::t_status r_status, n_status;
    logic [dwrs_pkg::KEY_W-1:0]   r_key, n_key;
    logic [CNT_W-1:0]             r_idx, n_idx;
    logic [CNT_W-1:0]             r_total, n_total;
    logic                         r_found, n_found;
    logic                         r_hit, n_hit;
    logic                         r_created, n_created;
    logic [dwrs_pkg::COUNT_W-1:0] r_count, n_count;
    logic [dwrs_pkg::SCORE_W-1:0] r_best, n_best;
    logic                         r_pick_valid, n_pick_valid;
    logic [dwrs_pkg::KEY_W-1:0]   r_pick_key, n_pick_key;

    logic                  w_match, w_first, w_score_nz, w_stock_nz, w_last, w_stop;
    logic                  w_full, w_below;
    logic [CNT_W-1:0]      w_idx_inc, w_addend;
    logic [STOCK_BITS-1:0] w_stock_dec, w_stock_inc;

    function automatic logic [dwrs_pkg::COUNT_W-1:0] f_report(input logic [STOCK_BITS-1:0] v);
        logic [RPT_W-1:0] ext;
        begin
            ext = RPT_W'(v);
            if (ext > RPT_W'(255)) begin
                f_report = '1;
            end else begin
                f_report = ext[dwrs_pkg::COUNT_W-1:0];
            end
        end
    endfunction

    assign w_match     = (i_rd_key == r_key);
    assign w_first     = w_match && !r_found;
    assign w_score_nz  = (i_rd_score != '0);
    assign w_stock_nz  = (i_rd_stock != '0);
    assign w_idx_inc   = r_idx + CNT_W'(1);
    assign w_last      = (w_idx_inc == r_total);
    assign w_stop      = w_last || (w_match &&
                         (r_func == dwrs_pkg::FN_QUERY || r_func == dwrs_pkg::FN_DEPOSIT));
    assign w_full      = (r_total == CNT_W'(MAX_POOLS));
    assign w_below     = (RPT_W'(i_rd_stock) < RPT_W'(i_stock_limit));
    // aging and boost folded: s - 1 + n when s is nonzero, else 0 + n
    assign w_addend    = r_total - CNT_W'(w_score_nz);
    assign w_stock_dec = w_stock_nz ? (i_rd_stock - STOCK_BITS'(1)) : i_rd_stock;
    assign w_stock_inc = (i_rd_stock == '1) ? i_rd_stock : (i_rd_stock + STOCK_BITS'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dwrs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (r_total == '0) ? dwrs_pkg::S_FINISH : dwrs_pkg::S_READ;
                end
            end
            dwrs_pkg::S_READ: begin
                n_state = dwrs_pkg::S_EXEC;
            end
            dwrs_pkg::S_EXEC: begin
                n_state = w_stop ? dwrs_pkg::S_FINISH : dwrs_pkg::S_READ;
            end
            dwrs_pkg::S_FINISH: begin
                n_state = dwrs_pkg::S_OUT;
            end
            dwrs_pkg::S_OUT: begin
                if (i_out_free) begin
                    n_state = dwrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dwrs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: table access, ALU control, handoff
    always_comb begin
        o_busy     = (r_state != dwrs_pkg::S_IDLE);
        o_done     = 1'b0;
        o_rd_addr  = r_idx[IDX_W-1:0];
        o_wr_addr  = r_idx[IDX_W-1:0];
        o_we       = '0;
        o_wr_key   = r_key;
        o_wr_score = i_alu_res;
        o_wr_stock = i_rd_stock;
        o_alu_op   = dwrs_pkg::ALU_DEC;
        o_alu_a    = i_rd_score;
        o_alu_b    = '0;
        case (r_state)
            dwrs_pkg::S_EXEC: begin
                case (r_func)
                    dwrs_pkg::FN_TAKE: begin
                        o_we.score = 1'b1;
                        if (w_first) begin
                            o_alu_op   = dwrs_pkg::ALU_ADD_SAT;
                            o_alu_b    = dwrs_pkg::SCORE_W'(w_addend);
                            o_we.stock = 1'b1;
                            o_wr_stock = w_stock_dec;
                        end
                    end
                    dwrs_pkg::FN_DEPOSIT: begin
                        if (w_match) begin
                            o_we.stock = 1'b1;
                            o_wr_stock = w_stock_inc;
                        end
                    end
                    dwrs_pkg::FN_PICK: begin
                        o_alu_op = dwrs_pkg::ALU_LT;
                        o_alu_a  = r_best;
                        o_alu_b  = i_rd_score;
                    end
                    default: begin
                        o_we = '0;
                    end
                endcase
            end
            dwrs_pkg::S_FINISH: begin
                if (r_func == dwrs_pkg::FN_TAKE && !r_found && !w_full) begin
                    o_we       = '1;
                    o_wr_addr  = r_total[IDX_W-1:0];
                    o_wr_score = dwrs_pkg::SCORE_W'(1);
                    o_wr_stock = '0;
                end
            end
            dwrs_pkg::S_OUT: begin
                o_done = i_out_free;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    // datapath register updates
    always_comb begin
        n_func       = r_func;
        n_key        = r_key;
        n_idx        = r_idx;
        n_total      = r_total;
        n_found      = r_found;
        n_hit        = r_hit;
        n_created    = r_created;
        n_status     = r_status;
        n_count      = r_count;
        n_best       = r_best;
        n_pick_valid = r_pick_valid;
        n_pick_key   = r_pick_key;
        case (r_state)
            dwrs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_func       = i_in_word.func;
                    n_key        = i_in_word.size_key;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_hit        = 1'b0;
                    n_created    = 1'b0;
                    n_status     = dwrs_pkg::ST_OK;
                    n_count      = '0;
                    n_best       = '0;
                    n_pick_valid = 1'b0;
                    n_pick_key   = '0;
                end
            end
            dwrs_pkg::S_EXEC: begin
                n_idx = w_idx_inc;
                case (r_func)
                    dwrs_pkg::FN_TAKE: begin
                        if (w_first) begin
                            n_found = 1'b1;
                            n_hit   = w_stock_nz;
                            n_count = f_report(w_stock_dec);
                        end
                    end
                    dwrs_pkg::FN_QUERY: begin
                        if (w_match) begin
                            n_found = 1'b1;
                            n_count = f_report(i_rd_stock);
                        end
                    end
                    dwrs_pkg::FN_DEPOSIT: begin
                        if (w_match) begin
                            n_found = 1'b1;
                            n_count = f_report(w_stock_inc);
                        end
                    end
                    dwrs_pkg::FN_PICK: begin
                        if (i_alu_flag && w_below) begin
                            n_best       = i_rd_score;
                            n_pick_valid = 1'b1;
                            n_pick_key   = i_rd_key;
                            n_count      = f_report(i_rd_stock);
                        end
                    end
                    default: begin
                        n_found = r_found;
                    end
                endcase
            end
            dwrs_pkg::S_FINISH: begin
                if (!r_found) begin
                    if (r_func == dwrs_pkg::FN_TAKE) begin
                        if (w_full) begin
                            n_status = dwrs_pkg::ST_FULL;
                        end else begin
                            n_created = 1'b1;
                            n_total   = r_total + CNT_W'(1);
                        end
                    end else if (r_func == dwrs_pkg::FN_QUERY ||
                                 r_func == dwrs_pkg::FN_DEPOSIT) begin
                        n_status = dwrs_pkg::ST_UNKNOWN;
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwrs_pkg::S_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_created    <= n_created;
        r_status     <= n_status;
        r_count      <= n_count;
        r_best       <= n_best;
        r_pick_valid <= n_pick_valid;
        r_pick_key   <= n_pick_key;
    end

    assign o_result = '{
        hit:         r_hit,
        created:     r_created,
        status:      r_status,
        stock_count: r_count,
        pick_valid:  r_pick_valid,
        pick_size:   r_pick_key
    };

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_POOLS))
        else $error("entry count above table size");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dwrs_pkg::S_READ || r_state == dwrs_pkg::S_EXEC) |-> r_idx < r_total)
        else $error("scan index past last entry");

    a_created_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dwrs_pkg::S_OUT && r_created) |->
        (r_func == dwrs_pkg::FN_TAKE && r_status == dwrs_pkg::ST_OK && !r_hit))
        else $error("created flag on wrong result");

    a_pick_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dwrs_pkg::S_EXEC && r_func == dwrs_pkg::FN_PICK) |-> o_we == '0)
        else $error("pick wrote the table");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dwrs_pkg::S_OUT && !i_out_free) |=> r_state == dwrs_pkg::S_OUT)
        else $error("result dropped while output full");

endmodule

`default_nettype wire

FILE: sv/demand_weighted_refill_scheduler_top.sv
// Demand weighted refill scheduler, top level.
// Input word: func and size_key; output word: hit, created, status,
// stock_count, pick_valid, pick_size. Both channels use valid/stall; a word
// moves on a rising edge with valid high and stall low.
// stock_limit is written over the APB port at byte address 0 (the user must
// do so only while idle; the block itself does no check). One word is worked
// at a time; o_in_stall is high from acceptance until the result is handed to
// the output register. A sequencer scans the valid table entries through one
// memory read port and a shared 32-bit ALU, with a read state and an exec state
// per entry. Take and pick scan all N entries; query and deposit stop at the
// matching entry. The next word is taken the cycle after the result is loaded.
// The output register holds one finished word; while the receiver stalls a
// second result waits in the sequencer and no new word is accepted.
// Reset empties the table, clears stock_limit (picks select nothing) and the
// output register; no clearing pass is needed.
// Depends on dwrs_pkg, dwrs_seq, dwrs_table, dwrs_alu.
`default_nettype none

module demand_weighted_refill_scheduler_top #(
    parameter int MAX_POOLS  = 8,
    parameter int STOCK_BITS = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire dwrs_pkg::t_in_word           i_in_word,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output dwrs_pkg::t_out_word               o_out_word,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [dwrs_pkg::APB_AW-1:0]        paddr,
    input  wire [dwrs_pkg::APB_DW-1:0]        pwdata,
    output logic [dwrs_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int IDX_W = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;

    logic [dwrs_pkg::LIMIT_W-1:0] r_stock_limit;
    logic                         r_out_valid;
    dwrs_pkg::t_out_word          r_out_word;

    logic                         w_start, w_busy, w_done, w_out_free, w_reg_sel;
    dwrs_pkg::t_out_word          w_result;
    logic [IDX_W-1:0]             w_rd_addr, w_wr_addr;
    dwrs_pkg::t_tbl_we            w_we;
    logic [dwrs_pkg::KEY_W-1:0]   w_wr_key, w_rd_key;
    logic [dwrs_pkg::SCORE_W-1:0] w_wr_score, w_rd_score;
    logic [STOCK_BITS-1:0]        w_wr_stock, w_rd_stock;
    dwrs_pkg::t_alu_op            w_alu_op;
    logic [dwrs_pkg::SCORE_W-1:0] w_alu_a, w_alu_b, w_alu_res;
    logic                         w_alu_flag;

    assign o_in_stall = w_busy;
    assign w_start    = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_reg_sel  = (paddr[dwrs_pkg::APB_AW-1:2] == dwrs_pkg::REG_STOCK_LIMIT);

    assign pready = 1'b1;
    assign prdata = w_reg_sel ? dwrs_pkg::APB_DW'(r_stock_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stock_limit <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_stock_limit <= pwdata[dwrs_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    dwrs_seq #(
        .MAX_POOLS  (MAX_POOLS),
        .STOCK_BITS (STOCK_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_in_word     (i_in_word),
        .i_stock_limit (r_stock_limit),
        .i_out_free    (w_out_free),
        .o_busy        (w_busy),
        .o_done        (w_done),
        .o_result      (w_result),
        .o_rd_addr     (w_rd_addr),
        .o_wr_addr     (w_wr_addr),
        .o_we          (w_we),
        .o_wr_key      (w_wr_key),
        .o_wr_score    (w_wr_score),
        .o_wr_stock    (w_wr_stock),
        .i_rd_key      (w_rd_key),
        .i_rd_score    (w_rd_score),
        .i_rd_stock    (w_rd_stock),
        .o_alu_op      (w_alu_op),
        .o_alu_a       (w_alu_a),
        .o_alu_b       (w_alu_b),
        .i_alu_res     (w_alu_res),
        .i_alu_flag    (w_alu_flag)
    );

    dwrs_table #(
        .MAX_POOLS  (MAX_POOLS),
        .STOCK_BITS (STOCK_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_we       (w_we),
        .i_wr_key   (w_wr_key),
        .i_wr_score (w_wr_score),
        .i_wr_stock (w_wr_stock),
        .o_rd_key   (w_rd_key),
        .o_rd_score (w_rd_score),
        .o_rd_stock (w_rd_stock)
    );

    dwrs_alu u_alu (
        .i_op   (w_alu_op),
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_res  (w_alu_res),
        .o_flag (w_alu_flag)
    );

endmodule

`default_nettype wire

FILE: tb/sv/demand_weighted_refill_scheduler_top_tb.sv
// Self-checking testbench for demand_weighted_refill_scheduler_top.
// Holds its own pool table to predict every reply; takes types and codes from dwrs_pkg.
// Random idling and stalls on both channels, with one long receiver hold-off.
`timescale 1ns / 100ps

module demand_weighted_refill_scheduler_top_tb;

    localparam int POOLS       = 8;
    localparam int STOCK_W     = 8;
    localparam int STOCK_MAX   = (1 << STOCK_W) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int RUN_LIMIT   = 500000;
    localparam int SETTLE      = 2 * POOLS + 3 + 12;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          in_stall;
    dwrs_pkg::t_in_word            in_word;
    logic                          out_valid;
    logic                          out_stall;
    dwrs_pkg::t_out_word           out_word;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dwrs_pkg::APB_AW-1:0]   paddr;
    logic [dwrs_pkg::APB_DW-1:0]   pwdata;
    logic [dwrs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    demand_weighted_refill_scheduler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // pool table shadow
    logic                         tbl_used  [POOLS];
    logic [dwrs_pkg::KEY_W-1:0]   tbl_key   [POOLS];
    logic [dwrs_pkg::SCORE_W-1:0] tbl_score [POOLS];
    logic [STOCK_W-1:0]           tbl_stock [POOLS];
    int unsigned                  tbl_count;
    logic [dwrs_pkg::LIMIT_W-1:0] limit_shadow;

    dwrs_pkg::t_in_word           queued_requests[$];
    dwrs_pkg::t_out_word          pending_replies[$];
    logic [dwrs_pkg::KEY_W-1:0]   known_keys[POOLS];

    logic                         send_idle;
    logic                         recv_idle;
    logic                         hold_go;
    int unsigned                  hold_left;
    int unsigned                  send_gap;
    int unsigned                  recv_wait;
    int unsigned                  cycles;
    int unsigned                  errors;
    int unsigned                  words_seen;
    int unsigned                  hits_seen;
    int unsigned                  creates_seen;
    int unsigned                  picks_seen;
    int unsigned                  misses_seen;
    logic [dwrs_pkg::LIMIT_W-1:0] mid_limit;

    function automatic dwrs_pkg::t_out_word serve_request(input dwrs_pkg::t_in_word w);
        dwrs_pkg::t_out_word          r;
        int                           i;
        int                           slot;
        int                           sel;
        logic [dwrs_pkg::SCORE_W-1:0] best;
        logic [dwrs_pkg::SCORE_W-1:0] boost;
        r    = '0;
        slot = -1;
        for (i = 0; i < POOLS; i++) begin
            if (slot < 0 && tbl_used[i] && tbl_key[i] == w.size_key) begin
                slot = i;
            end
        end
        case (w.func)
            dwrs_pkg::FN_TAKE: begin
                boost = dwrs_pkg::SCORE_W'(tbl_count);
                for (i = 0; i < POOLS; i++) begin
                    if (tbl_used[i] && tbl_score[i] != '0) begin
                        tbl_score[i] = tbl_score[i] - dwrs_pkg::SCORE_W'(1);
                    end
                end
                if (slot >= 0) begin
                    if (tbl_score[slot] > ({dwrs_pkg::SCORE_W{1'b1}} - boost)) begin
                        tbl_score[slot] = '1;
                    end else begin
                        tbl_score[slot] = tbl_score[slot] + boost;
                    end
                    if (tbl_stock[slot] != '0) begin
                        tbl_stock[slot] = tbl_stock[slot] - STOCK_W'(1);
                        r.hit = 1'b1;
                    end
                    r.stock_count = tbl_stock[slot];
                end else if (tbl_count < POOLS) begin
                    tbl_used[tbl_count]  = 1'b1;
                    tbl_key[tbl_count]   = w.size_key;
                    tbl_score[tbl_count] = 1;
                    tbl_stock[tbl_count] = '0;
                    tbl_count++;
                    r.created = 1'b1;
                end else begin
                    r.status = dwrs_pkg::ST_FULL;
                end
            end
            dwrs_pkg::FN_QUERY: begin
                if (slot >= 0) begin
                    r.stock_count = tbl_stock[slot];
                end else begin
                    r.status = dwrs_pkg::ST_UNKNOWN;
                end
            end
            dwrs_pkg::FN_PICK: begin
                best = '0;
                sel  = -1;
                for (i = 0; i < POOLS; i++) begin
                    if (tbl_used[i] && tbl_score[i] > best && tbl_stock[i] < limit_shadow) begin
                        best = tbl_score[i];
                        sel  = i;
                    end
                end
                if (sel >= 0) begin
                    r.pick_valid  = 1'b1;
                    r.pick_size   = tbl_key[sel];
                    r.stock_count = tbl_stock[sel];
                end
            end
            default: begin
                if (slot >= 0) begin
                    if (tbl_stock[slot] != STOCK_W'(STOCK_MAX)) begin
                        tbl_stock[slot] = tbl_stock[slot] + STOCK_W'(1);
                    end
                    r.stock_count = tbl_stock[slot];
                end else begin
                    r.status = dwrs_pkg::ST_UNKNOWN;
                end
            end
        endcase
        return r;
    endfunction

    function automatic dwrs_pkg::t_in_word make_request(input dwrs_pkg::t_func f,
                                                        input logic [dwrs_pkg::KEY_W-1:0] k);
        dwrs_pkg::t_in_word w;
        w.func     = f;
        w.size_key = k;
        return w;
    endfunction

    function automatic int unsigned draw_idle(input logic en);
        return en ? $urandom_range(0, 12) : 0;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                pending_replies.push_back(serve_request(in_word));
            end
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (queued_requests.size() != 0) begin
                in_word  <= queued_requests.pop_front();
                in_valid <= 1'b1;
                send_gap <= draw_idle(send_idle);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // reply monitor
    always @(posedge i_clk) begin : reply_mon
        int unsigned         nxt;
        dwrs_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end else begin
            nxt = recv_wait;
            if (out_valid && !out_stall) begin
                words_seen++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply word with nothing expected: %h", $time, out_word);
                    errors++;
                end else begin
                    exp_w = pending_replies.pop_front();
                    compare_field("hit", int'(exp_w.hit), int'(out_word.hit));
                    compare_field("created", int'(exp_w.created), int'(out_word.created));
                    compare_field("status", int'(exp_w.status), int'(out_word.status));
                    compare_field("stock_count", int'(exp_w.stock_count),
                                  int'(out_word.stock_count));
                    compare_field("pick_valid", int'(exp_w.pick_valid),
                                  int'(out_word.pick_valid));
                    compare_field("pick_size", int'(exp_w.pick_size), int'(out_word.pick_size));
                    hits_seen    += 32'(exp_w.hit);
                    creates_seen += 32'(exp_w.created);
                    picks_seen   += 32'(exp_w.pick_valid);
                    misses_seen  += 32'(exp_w.status != dwrs_pkg::ST_OK);
                end
                nxt = draw_idle(recv_idle);
            end else if (out_valid && nxt != 0) begin
                nxt = nxt - 1;
            end
            recv_wait <= nxt;
            out_stall <= (nxt != 0) || (hold_left != 0);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("%0t: timeout, %0d replies still expected", $time, pending_replies.size());
            $display("** demand_weighted_refill_scheduler_top: FAILED **");
            $finish;
        end
    end

    task automatic write_limit(input logic [dwrs_pkg::LIMIT_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {dwrs_pkg::REG_STOCK_LIMIT, 2'b00};
        pwdata  <= dwrs_pkg::APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_shadow = v;
        @(posedge i_clk);
        if (!pready || prdata != dwrs_pkg::APB_DW'(v)) begin
            $display("%0t: mismatch on stock_limit readback: expected %0d, actual %0d",
                     $time, v, prdata);
            errors++;
        end
    endtask

    task automatic drain();
        while (queued_requests.size() != 0 || in_valid || pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_random(input int unsigned n);
        int unsigned                i;
        int unsigned                r;
        dwrs_pkg::t_func            f;
        logic [dwrs_pkg::KEY_W-1:0] k;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                f = dwrs_pkg::FN_TAKE;
            end else if (r < 50) begin
                f = dwrs_pkg::FN_QUERY;
            end else if (r < 70) begin
                f = dwrs_pkg::FN_PICK;
            end else begin
                f = dwrs_pkg::FN_DEPOSIT;
            end
            if ($urandom_range(0, 99) < 85) begin
                k = known_keys[$urandom_range(0, POOLS - 1)];
            end else begin
                k = dwrs_pkg::KEY_W'($urandom_range(0, (1 << dwrs_pkg::KEY_W) - 1));
            end
            queued_requests.push_back(make_request(f, k));
        end
    endtask

    initial begin : stimulus
        int i;
        for (i = 0; i < POOLS; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_key[i]   = '0;
            tbl_score[i] = '0;
            tbl_stock[i] = '0;
        end
        tbl_count    = 0;
        limit_shadow = '0;
        known_keys   = '{11'd0, 11'd2047, 11'd1024, 11'd1, 11'd3, 11'd7, 11'd11, 11'd13};
        errors       = 0;
        words_seen   = 0;
        hits_seen    = 0;
        creates_seen = 0;
        picks_seen   = 0;
        misses_seen  = 0;
        cycles       = 0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_go      = 1'b0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, fill it, overflow, stock moves
        write_limit(8'd2);
        queued_requests.push_back(make_request(dwrs_pkg::FN_QUERY, 11'd5));
        queued_requests.push_back(make_request(dwrs_pkg::FN_DEPOSIT, 11'd5));
        queued_requests.push_back(make_request(dwrs_pkg::FN_PICK, 11'd0));
        for (i = 0; i < POOLS; i++) begin
            queued_requests.push_back(make_request(dwrs_pkg::FN_TAKE, known_keys[i]));
        end
        queued_requests.push_back(make_request(dwrs_pkg::FN_TAKE, 11'd17));
        queued_requests.push_back(make_request(dwrs_pkg::FN_DEPOSIT, 11'd2047));
        queued_requests.push_back(make_request(dwrs_pkg::FN_DEPOSIT, 11'd2047));
        queued_requests.push_back(make_request(dwrs_pkg::FN_DEPOSIT, 11'd0));
        queued_requests.push_back(make_request(dwrs_pkg::FN_QUERY, 11'd2047));
        queued_requests.push_back(make_request(dwrs_pkg::FN_PICK, 11'd2047));
        queued_requests.push_back(make_request(dwrs_pkg::FN_TAKE, 11'd2047));
        queued_requests.push_back(make_request(dwrs_pkg::FN_TAKE, 11'd0));
        queued_requests.push_back(make_request(dwrs_pkg::FN_TAKE, 11'd0));
        queued_requests.push_back(make_request(dwrs_pkg::FN_PICK, 11'd1365));
        queued_requests.push_back(make_request(dwrs_pkg::FN_QUERY, 11'd17));
        queued_requests.push_back(make_request(dwrs_pkg::FN_DEPOSIT, 11'd1234));
        drain();

        // no idling on either side
        write_limit(8'd255);
        send_idle <= 1'b0;
        recv_idle <= 1'b0;
        queue_random(150);
        drain();

        // stock saturation on one pool
        send_idle <= 1'b1;
        recv_idle <= 1'b1;
        for (i = 0; i < STOCK_MAX + 5; i++) begin
            queued_requests.push_back(make_request(dwrs_pkg::FN_DEPOSIT, 11'd1));
        end
        queued_requests.push_back(make_request(dwrs_pkg::FN_QUERY, 11'd1));
        queued_requests.push_back(make_request(dwrs_pkg::FN_PICK, 11'd0));
        queued_requests.push_back(make_request(dwrs_pkg::FN_TAKE, 11'd1));
        drain();

        // refill disabled, receiver holds off while the sender keeps offering
        write_limit(8'd0);
        send_idle <= 1'b0;
        queue_random(150);
        repeat (30) @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        drain();

        write_limit(8'd1);
        send_idle <= 1'b1;
        queue_random(150);
        drain();

        mid_limit = dwrs_pkg::LIMIT_W'($urandom_range(2, 254));
        write_limit(mid_limit);
        recv_idle <= 1'b0;
        queue_random(150);
        drain();

        write_limit(8'd8);
        recv_idle <= 1'b1;
        queue_random(150);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        $display("Checked %0d reply words: %0d take hits, %0d pools made, %0d picks selected,",
                 words_seen, hits_seen, creates_seen, picks_seen);
        $display("%0d unknown/full answers; stock limits 2, 255, 0, 1, %0d, 8; one long hold-off.",
                 misses_seen, mid_limit);
        if (errors == 0) begin
            $display("** demand_weighted_refill_scheduler_top: PASSED **");
        end else begin
            $display("** demand_weighted_refill_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule
